// ===== hw/rtl/tdf_pkg.sv =====
// Package for the triangle duplicate filter: sizes, entry layout, state codes, key helpers.
`default_nettype none
package tdf_pkg;

  localparam int INDEX_BITS = 20;
  localparam int SET_DEPTH  = 4096;
  localparam int FIELD_W    = 20;

  localparam int CORNER_USED = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
  localparam int KEY_W       = 3 * INDEX_BITS;
  localparam int ADDR_W      = $clog2(SET_DEPTH);
  localparam int CNT_W       = $clog2(SET_DEPTH + 1);
  localparam int EPOCH_W     = 8;
  localparam int FOLD_N      = (KEY_W + ADDR_W - 1) / ADDR_W;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [EPOCH_W-1:0]    epoch_t;

  localparam epoch_t EPOCH_MAX  = '1;
  localparam epoch_t EPOCH_NONE = '0;
  localparam epoch_t EPOCH_INIT = epoch_t'(1);
  localparam cnt_t   DEPTH_CNT  = cnt_t'(SET_DEPTH);
  localparam addr_t  LAST_ADDR  = addr_t'(SET_DEPTH - 1);

  typedef struct packed {
    epoch_t epoch;
    key_t   key;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SORT,
    ST_PROBE,
    ST_CHECK,
    ST_EMIT
  } state_t;

  // ascending sort, smallest index in the low bits
  function automatic key_t make_key(input index_t a, input index_t b, input index_t c);
    index_t x;
    index_t y;
    index_t z;
    index_t t;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    return {z, y, x};
  endfunction

  // xor fold into a home slot, brought below the depth
  function automatic addr_t home_slot(input key_t key);
    logic [FOLD_N*ADDR_W-1:0] padded;
    addr_t                    h;
    padded = '0;
    padded[KEY_W-1:0] = key;
    h = '0;
    for (int i = 0; i < FOLD_N; i++) begin
      h = h ^ padded[i*ADDR_W +: ADDR_W];
    end
    if ({1'b0, h} > {1'b0, LAST_ADDR}) begin
      h = addr_t'({1'b0, h} - (ADDR_W + 1)'(SET_DEPTH));
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/triangle_duplicate_filter_top.sv =====
// Triangle duplicate filter: sorted-key lookup in a linearly probed set memory.
`default_nettype none
// Each triangle is taken as three vertex indices and a restart flag. The
// indices are sorted into a key that is looked up in a hashed set held in one
// synchronous memory, probed linearly from the key's home slot. A new key is
// stored and its triangle passed on in original corner order; a repeat is
// dropped. With the set full, a new key is passed on with table_overflow set
// and not stored. Each probe is one memory read and one compare; a repeat
// that is found is dropped at once, while a new key waits to be passed on for
// as long as a stalled result still holds the output register. An absent key
// with the set full is probed at all SET_DEPTH slots.
// Entries carry an epoch mark so that restart empties the set at once. After
// reset, and on every 255th restart, a clearing pass sweeps all SET_DEPTH
// (4096) slots of the memory; no item is taken after reset until it ends. A
// result waits in an output register, and the next item is taken meanwhile.
module triangle_duplicate_filter_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        tri_valid,
  output logic                             tri_stall,
  input  wire logic [tdf_pkg::FIELD_W-1:0] corner_a,
  input  wire logic [tdf_pkg::FIELD_W-1:0] corner_b,
  input  wire logic [tdf_pkg::FIELD_W-1:0] corner_c,
  input  wire logic                        restart,
  output logic                             kept_valid,
  input  wire logic                        kept_stall,
  output logic      [tdf_pkg::FIELD_W-1:0] out_corner_a,
  output logic      [tdf_pkg::FIELD_W-1:0] out_corner_b,
  output logic      [tdf_pkg::FIELD_W-1:0] out_corner_c,
  output logic                             table_overflow
);

  tdf_pkg::state_t state, state_next;

  tdf_pkg::entry_t mem [tdf_pkg::SET_DEPTH];
  tdf_pkg::entry_t rd_entry;
  tdf_pkg::entry_t mem_wdata;
  tdf_pkg::addr_t  mem_waddr;
  logic            mem_we;
  logic            mem_re;

  tdf_pkg::index_t a_r, b_r, c_r;
  logic            restart_r;
  tdf_pkg::key_t   key_r;
  tdf_pkg::addr_t  probe_addr;
  tdf_pkg::cnt_t   probes;
  tdf_pkg::epoch_t epoch;
  tdf_pkg::addr_t  clr_addr;
  logic            clr_resume;
  logic            ovf_r;

  logic accept;
  logic hit;
  logic empty;
  logic last_probe;
  logic out_free;
  logic out_load;
  logic epoch_wrap;

  assign accept     = tri_valid && !tri_stall;
  assign empty      = rd_entry.epoch != epoch;
  assign hit        = !empty && (rd_entry.key == key_r);
  assign last_probe = (probes + tdf_pkg::cnt_t'(1)) == tdf_pkg::DEPTH_CNT;
  assign out_free   = !kept_valid || !kept_stall;
  assign epoch_wrap = restart_r && (epoch == tdf_pkg::EPOCH_MAX);

  always_comb begin
    state_next = state;
    unique case (state)
      tdf_pkg::ST_CLEAR: begin
        if (clr_addr == tdf_pkg::LAST_ADDR) begin
          state_next = clr_resume ? tdf_pkg::ST_PROBE : tdf_pkg::ST_IDLE;
        end
      end
      tdf_pkg::ST_IDLE: begin
        if (tri_valid) state_next = tdf_pkg::ST_SORT;
      end
      tdf_pkg::ST_SORT: begin
        state_next = epoch_wrap ? tdf_pkg::ST_CLEAR : tdf_pkg::ST_PROBE;
      end
      tdf_pkg::ST_PROBE: state_next = tdf_pkg::ST_CHECK;
      tdf_pkg::ST_CHECK: begin
        priority if (hit) begin
          state_next = tdf_pkg::ST_IDLE;
        end else if (empty || last_probe) begin
          state_next = tdf_pkg::ST_EMIT;
        end else begin
          state_next = tdf_pkg::ST_PROBE;
        end
      end
      tdf_pkg::ST_EMIT: begin
        if (out_free) state_next = tdf_pkg::ST_IDLE;
      end
      default: state_next = tdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    tri_stall = 1'b1;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = probe_addr;
    mem_wdata = '{epoch: epoch, key: key_r};
    out_load  = 1'b0;
    unique case (state)
      tdf_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '{epoch: tdf_pkg::EPOCH_NONE, key: '0};
      end
      tdf_pkg::ST_IDLE:  tri_stall = 1'b0;
      tdf_pkg::ST_SORT:  ;
      tdf_pkg::ST_PROBE: mem_re = 1'b1;
      tdf_pkg::ST_CHECK: mem_we = empty;
      tdf_pkg::ST_EMIT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_entry <= mem[probe_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tdf_pkg::ST_CLEAR;
      epoch        <= tdf_pkg::EPOCH_INIT;
      clr_addr     <= '0;
      clr_resume   <= 1'b0;
      kept_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tdf_pkg::ST_CLEAR) clr_addr <= clr_addr + tdf_pkg::addr_t'(1);
      if (state == tdf_pkg::ST_SORT && restart_r) begin
        if (epoch_wrap) begin
          epoch      <= tdf_pkg::EPOCH_INIT;
          clr_addr   <= '0;
          clr_resume <= 1'b1;
        end else begin
          epoch <= epoch + tdf_pkg::epoch_t'(1);
        end
      end
      if (out_load) begin
        kept_valid <= 1'b1;
      end else if (!kept_stall) begin
        kept_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r       <= tdf_pkg::index_t'(corner_a[tdf_pkg::CORNER_USED-1:0]);
      b_r       <= tdf_pkg::index_t'(corner_b[tdf_pkg::CORNER_USED-1:0]);
      c_r       <= tdf_pkg::index_t'(corner_c[tdf_pkg::CORNER_USED-1:0]);
      restart_r <= restart;
    end
    if (state == tdf_pkg::ST_SORT) begin
      key_r      <= tdf_pkg::make_key(a_r, b_r, c_r);
      probe_addr <= tdf_pkg::home_slot(tdf_pkg::make_key(a_r, b_r, c_r));
      probes     <= '0;
    end
    if (state == tdf_pkg::ST_CHECK) begin
      ovf_r <= !empty;
      if (!hit && !empty && !last_probe) begin
        probes     <= probes + tdf_pkg::cnt_t'(1);
        probe_addr <= (probe_addr == tdf_pkg::LAST_ADDR) ? '0
                                                         : probe_addr + tdf_pkg::addr_t'(1);
      end
    end
    if (out_load) begin
      out_corner_a   <= tdf_pkg::FIELD_W'(a_r);
      out_corner_b   <= tdf_pkg::FIELD_W'(b_r);
      out_corner_c   <= tdf_pkg::FIELD_W'(c_r);
      table_overflow <= ovf_r;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_triangle_duplicate_filter_top.sv =====
// Testbench for the triangle duplicate filter: directed table, then a random mix.
`timescale 1ns / 1ps
module tb_triangle_duplicate_filter_top;

  typedef logic [tdf_pkg::FIELD_W-1:0] corner_t;

  typedef struct packed {
    corner_t a;
    corner_t b;
    corner_t c;
  } tri_t;

  typedef struct packed {
    corner_t a;
    corner_t b;
    corner_t c;
    logic    ovf;
  } kept_t;

  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_KEEP,
    EXP_DROP
  } outcome_t;

  typedef struct packed {
    corner_t  a;
    corner_t  b;
    corner_t  c;
    logic     rs;
    outcome_t how;
  } row_t;

  localparam int DIR_ROWS = 24;
  localparam int RANDOM_ITEMS = 750;

  logic    clk = 1'b0;
  logic    rst;
  logic    tri_valid;
  logic    tri_stall;
  corner_t corner_a;
  corner_t corner_b;
  corner_t corner_c;
  logic    restart;
  logic    kept_valid;
  logic    kept_stall = 1'b0;
  corner_t out_corner_a;
  corner_t out_corner_b;
  corner_t out_corner_c;
  logic    table_overflow;

  bit calm = 1'b0;

  bit          seen_keys_m [tdf_pkg::key_t];
  int unsigned seen_fill;
  kept_t       kept_queue [$];
  tri_t        recent [$];
  row_t        dir_rows [DIR_ROWS];

  int n_sent      = 0;
  int n_restarts  = 0;
  int n_drops     = 0;
  int n_overflows = 0;
  int n_checked   = 0;
  int n_mismatch  = 0;

  triangle_duplicate_filter_top dut (
    .clk            (clk),
    .rst            (rst),
    .tri_valid      (tri_valid),
    .tri_stall      (tri_stall),
    .corner_a       (corner_a),
    .corner_b       (corner_b),
    .corner_c       (corner_c),
    .restart        (restart),
    .kept_valid     (kept_valid),
    .kept_stall     (kept_stall),
    .out_corner_a   (out_corner_a),
    .out_corner_b   (out_corner_b),
    .out_corner_c   (out_corner_c),
    .table_overflow (table_overflow)
  );

  always #5 clk = ~clk;

  // returns 1 when the triangle is passed on; keeps its own copy of the seen set
  function automatic bit filter_triangle(input tri_t t, input logic rs, output kept_t res);
    tdf_pkg::index_t a;
    tdf_pkg::index_t b;
    tdf_pkg::index_t c;
    tdf_pkg::index_t lo;
    tdf_pkg::index_t hi;
    tdf_pkg::index_t mid;
    tdf_pkg::key_t   key;
    a = tdf_pkg::index_t'(t.a);
    b = tdf_pkg::index_t'(t.b);
    c = tdf_pkg::index_t'(t.c);
    if (rs) begin
      seen_keys_m.delete();
      seen_fill = 0;
    end
    lo = a;
    if (b < lo) lo = b;
    if (c < lo) lo = c;
    hi = a;
    if (b > hi) hi = b;
    if (c > hi) hi = c;
    mid = a ^ b ^ c ^ lo ^ hi;
    key = {hi, mid, lo};
    res = '{corner_t'(a), corner_t'(b), corner_t'(c), 1'b0};
    if (seen_keys_m.exists(key)) return 1'b0;
    if (seen_fill < tdf_pkg::SET_DEPTH) begin
      seen_keys_m[key] = 1'b1;
      seen_fill++;
    end else begin
      res.ovf = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic tri_t shuffle_corners(input tri_t t, input int sel);
    case (sel)
      0:       return '{t.a, t.b, t.c};
      1:       return '{t.a, t.c, t.b};
      2:       return '{t.b, t.a, t.c};
      3:       return '{t.b, t.c, t.a};
      4:       return '{t.c, t.a, t.b};
      default: return '{t.c, t.b, t.a};
    endcase
  endfunction

  task automatic send_triangle(input tri_t t, input logic rs, input outcome_t how);
    int    gap;
    bit    kept;
    kept_t res;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < 19) gap++;
    if (gap > 0) begin
      tri_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tri_valid <= 1'b1;
    corner_a  <= t.a;
    corner_b  <= t.b;
    corner_c  <= t.c;
    restart   <= rs;
    @(posedge clk);
    while (tri_stall) @(posedge clk);
    kept = filter_triangle(t, rs, res);
    n_sent++;
    if (rs) n_restarts++;
    case (how)
      EXP_KEEP: kept_queue.push_back('{t.a, t.b, t.c, 1'b0});
      EXP_DROP: ;
      default:  if (kept) kept_queue.push_back(res);
    endcase
    if (!kept) n_drops++;
    else if (res.ovf) n_overflows++;
  endtask

  task automatic log_mismatch(input string what, input kept_t e);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch (%s): expected a=%h b=%h c=%h ovf=%b, got a=%h b=%h c=%h ovf=%b",
               what, e.a, e.b, e.c, e.ovf,
               out_corner_a, out_corner_b, out_corner_c, table_overflow);
  endtask

  always @(posedge clk) kept_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 19);

  always @(posedge clk) begin : watch_kept
    kept_t e;
    if (!rst && kept_valid && !kept_stall) begin
      if (kept_queue.size() == 0) begin
        log_mismatch("no item expected", '0);
      end else begin
        e = kept_queue.pop_front();
        n_checked++;
        if (out_corner_a !== e.a || out_corner_b !== e.b ||
            out_corner_c !== e.c || table_overflow !== e.ovf)
          log_mismatch("field", e);
      end
    end
  end

  initial begin : stimulus
    tri_t       t;
    corner_t    v;
    corner_t    w;
    int         p;
    int         wait_n;

    dir_rows = '{
      '{20'h00000, 20'h00000, 20'h00000, 1'b0, EXP_KEEP},
      '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0, EXP_KEEP},
      '{20'h00000, 20'h00000, 20'h00000, 1'b0, EXP_DROP},
      '{20'hFFFFF, 20'h00000, 20'h00001, 1'b0, EXP_KEEP},
      '{20'h00001, 20'hFFFFF, 20'h00000, 1'b0, EXP_DROP},
      '{20'h00000, 20'h00001, 20'hFFFFF, 1'b0, EXP_DROP},
      '{20'h00005, 20'h00005, 20'h00009, 1'b0, EXP_KEEP},
      '{20'h00009, 20'h00005, 20'h00005, 1'b0, EXP_DROP},
      '{20'h00005, 20'h00009, 20'h00009, 1'b0, EXP_KEEP},
      '{20'h00000, 20'h00000, 20'h00000, 1'b1, EXP_KEEP},
      '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0, EXP_KEEP},
      '{20'hFFFFF, 20'h00000, 20'h00001, 1'b0, EXP_KEEP},
      '{20'hAAAAA, 20'h55555, 20'h12345, 1'b0, EXP_KEEP},
      '{20'h55555, 20'h12345, 20'hAAAAA, 1'b1, EXP_KEEP},
      '{20'hAAAAA, 20'h12345, 20'h55555, 1'b0, EXP_DROP},
      '{20'h12345, 20'hAAAAA, 20'h55555, 1'b1, EXP_KEEP},
      '{20'h80000, 20'h00001, 20'h7FFFF, 1'b0, EXP_PREDICT},
      '{20'h00001, 20'h80000, 20'h7FFFF, 1'b0, EXP_PREDICT},
      '{20'h7FFFF, 20'h7FFFF, 20'h80000, 1'b0, EXP_PREDICT},
      '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, EXP_KEEP},
      '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, EXP_KEEP},
      '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0, EXP_DROP},
      '{20'h00000, 20'hFFFFF, 20'hFFFFF, 1'b0, EXP_PREDICT},
      '{20'hFFFFF, 20'h00000, 20'hFFFFF, 1'b0, EXP_PREDICT}
    };

    seen_fill = 0;
    rst       <= 1'b1;
    tri_valid <= 1'b0;
    corner_a  <= '0;
    corner_b  <= '0;
    corner_c  <= '0;
    restart   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_triangle('{dir_rows[i].a, dir_rows[i].b, dir_rows[i].c},
                    dir_rows[i].rs, dir_rows[i].how);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm <= (i >= 250 && i < 400);
      p = $urandom_range(0, 99);
      if (p < 40 && recent.size() > 0) begin
        t = shuffle_corners(recent[$urandom_range(0, recent.size() - 1)],
                            $urandom_range(0, 5));
      end else if (p < 50) begin
        v = corner_t'($urandom);
        w = $urandom_range(0, 1) ? corner_t'($urandom) : corner_t'($urandom_range(0, 15));
        t = shuffle_corners('{v, v, w}, $urandom_range(0, 5));
      end else if (p < 70) begin
        t = '{corner_t'($urandom_range(0, 15)), corner_t'($urandom_range(0, 15)),
              corner_t'($urandom_range(0, 15))};
      end else begin
        t = '{corner_t'($urandom), corner_t'($urandom), corner_t'($urandom)};
      end
      send_triangle(t, i == 0 || $urandom_range(0, 99) < 3, EXP_PREDICT);
      recent.push_back(t);
      if (recent.size() > 16) void'(recent.pop_front());
    end
    tri_valid <= 1'b0;
    calm      <= 1'b0;

    wait_n = 0;
    while (kept_queue.size() != 0 && wait_n < 4 * tdf_pkg::SET_DEPTH) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (2 * tdf_pkg::SET_DEPTH + 8) @(posedge clk);
    if (kept_queue.size() != 0) begin
      $display("%0d expected results never arrived", kept_queue.size());
      n_mismatch += kept_queue.size();
    end

    $display("Sent %0d triangles with %0d restarts; %0d dropped as repeats, %0d passed on a full set",
             n_sent, n_restarts, n_drops, n_overflows);
    $display("Checked %0d kept triangles, %0d mismatches", n_checked, n_mismatch);
    if (n_mismatch == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
